// File: src/pts_pkg.sv
// Shared types and constants of the pooled two-sample t statistic block.
`default_nettype none
package pts_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int VALUE_W = 32;
	localparam int SQ_SHIFT = 12;
	localparam int VAR_FRAC_HALF = 10;
	localparam int EXP_MAX = 31;
	localparam logic [63:0] NORM_TOP = 64'h4000_0000_0000_0000;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FEW   = 2'd2,
		STAT_SAT   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_CHECK,
		ST_MEAN0,
		ST_MEAN0_W,
		ST_MEAN1,
		ST_MEAN1_W,
		ST_DM,
		ST_SS_ADDR,
		ST_SS_DIFF,
		ST_SS_MUL,
		ST_SS_ACC,
		ST_VAR_MUL,
		ST_VAR_MUL_W,
		ST_VAR_DIV,
		ST_VAR_DIV_W,
		ST_NORM,
		ST_SQRT,
		ST_TDIV,
		ST_TDIV_W,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// File: src/pts_in_if.sv
// Sample request channel: valid, ready and one sample.
`default_nettype none
interface pts_in_if;
	import pts_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sample_value;
	logic                      group_label;
	logic                      last_sample;

	modport source(output valid, output sample_value, output group_label,
		output last_sample, input ready);
	modport sink(input valid, input sample_value, input group_label,
		input last_sample, output ready);
endinterface
`default_nettype wire

// File: src/pts_out_if.sv
// Result request channel: valid, ready and one t statistic with status.
`default_nettype none
interface pts_out_if;
	import pts_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] t_statistic;
	logic [1:0]                status;

	modport source(output valid, output t_statistic, output status, input ready);
	modport sink(input valid, input t_statistic, input status, output ready);
endinterface
`default_nettype wire

// File: src/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pts_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: src/pts_sdiv.sv
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
`default_nettype none
module pts_sdiv #(
	parameter int DVW = 76,
	parameter int DSW = 33
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DVW-1:0]    dividend,
	input  wire logic [DSW-1:0]    divisor,
	output pts_pkg::div_stat_t     stat,
	output logic      [DVW-1:0]    quotient,
	output logic      [DSW-1:0]    remainder
);
	import pts_pkg::*;
	localparam int KW = $clog2(DVW + 1);

	logic [DVW-1:0] quo_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic [KW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DSW:0]   trial;
	logic           fits;

	always_comb begin
		trial = {rem_q, quo_q[DVW-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(DVW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - KW'(1);
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift the dividend out at the top, the quotient in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DSW'(trial - {1'b0, dsr_q}) : trial[DSW-1:0];
			quo_q <= {quo_q[DVW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: src/pooled_two_sample_t_statistic_top.sv
// Top level of the pooled two-sample t statistic block.
`default_nettype none
// Streams one gene's samples (signed Q16.16 value plus group label) and,
// on the sample flagged last, returns t = (mean1 - mean0) / se in Q16.16 with
// a status (0 ok, 1 a group empty, 2 fewer than three samples, 3 saturated).
// While loading, one sample request is taken every cycle; samples beyond
// MAX_SAMPLES are dropped but a last flag on them still closes the gene.
// After the last sample the block stops taking requests until the result is
// finished; that time grows with n, the stored sample count, and with DVW, the
// serial divider width (75 at the default of 64 samples). It is set by the
// one-bit-per-cycle divider (both group means, the pooled variance and the
// final quotient), the bit-serial squaring of each deviation (one RAM read
// each) and the two-bits-per-cycle square root. A finished result sits in an
// output register until taken; the block goes back to loading as soon as it
// has placed the result there, and only waits if an older result is still
// pending. Empty groups and short genes skip the arithmetic and go from the
// check straight to the result.
module pooled_two_sample_t_statistic_top #(
	parameter int MAX_SAMPLES = pts_pkg::MAX_SAMPLES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pts_in_if.sink   samples,
	pts_out_if.source results
);
	import pts_pkg::*;

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int SW   = VALUE_W + CW;
	localparam int AVW  = SW + 2;
	localparam int MEW  = VALUE_W + 1;
	localparam int DFW  = VALUE_W + 2;
	localparam int UW   = VALUE_W + 1;
	localparam int SSW  = 2 * UW - SQ_SHIFT + CW;
	localparam int PW   = SSW + CW;
	localparam int MW   = (PW > 2 * UW) ? PW : 2 * UW;
	localparam int TNW  = DFW + VAR_FRAC_HALF + EXP_MAX;
	localparam int DVW  = (PW > TNW) ? PW : TNW;
	localparam int DSW  = (3 * CW > VALUE_W) ? 3 * CW : VALUE_W;
	localparam int MKW  = $clog2(UW + 1);
	localparam int RW   = VALUE_W + 1;

	// control
	state_t state_q, state_d;
	logic   in_ready;
	logic   ram_re;
	logic   div_start;
	logic   accept;
	logic   out_load;

	// per-gene accumulators
	logic signed [SW-1:0] sum0_q, sum1_q;
	logic [CW-1:0]        cnt0_q, cnt1_q;
	logic [CW-1:0]        n_tot;
	logic                 full;

	// finishing datapath
	logic signed [MEW-1:0] mean0_q, mean1_q;
	logic signed [DFW-1:0] dm_q;
	logic [CW-1:0]         idx_q;
	logic [SSW-1:0]        ss_q;
	logic [MW-1:0]         mul_a_q, mul_acc_q;
	logic [UW-1:0]         mul_b_q;
	logic [MKW-1:0]        mul_cnt_q;
	logic [2*CW-1:0]       pdiv1_q;
	logic [DSW-1:0]        divisor_q;
	logic [63:0]           w_q;
	logic [5:0]            s_q;
	logic [63:0]           sq_rem_q, sq_res_q, sq_bit_q;
	logic signed [VALUE_W-1:0] res_t_q;
	status_t               res_st_q;
	logic signed [VALUE_W-1:0] out_t_q;
	status_t               out_st_q;
	logic                  out_valid_q;

	// RAM
	logic [RW-1:0] ram_rdata;

	// divider
	div_stat_t      div_stat;
	logic [DVW-1:0] div_dvd, div_quo;
	logic [DSW-1:0] div_dsr, div_rem;

	// combinational helpers
	logic signed [SW-1:0]  sum_sel;
	logic [CW-1:0]         cnt_sel;
	logic signed [AVW-1:0] a_val;
	logic                  a_neg;
	logic [AVW-1:0]        a_mag;
	logic [MEW:0]          mq;
	logic signed [MEW:0]   mres;
	logic signed [DFW-1:0] dm_d;
	logic signed [DFW-1:0] dev;
	logic [UW-1:0]         dev_mag;
	logic [DFW-1:0]        dm_mag;
	logic [5:0]            expo;
	logic [DVW-1:0]        t_num;
	logic [DVW-1:0]        t_lim;
	logic [63:0]           sq_trial;
	logic                  sq_ge;

	assign n_tot  = CW'(cnt0_q + cnt1_q);
	assign full   = n_tot == CW'(MAX_SAMPLES);
	assign accept = samples.valid && in_ready;

	// Sample store: value and label of every counted sample.
	pts_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (accept && !full),
		.waddr(n_tot[AW-1:0]),
		.wdata({samples.group_label, samples.sample_value}),
		.re   (ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	pts_sdiv #(
		.DVW(DVW),
		.DSW(DSW)
	) u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Rounded mean: floor((2*sum + cnt) / (2*cnt)), from magnitude division.
	always_comb begin
		if (state_q == ST_MEAN1 || state_q == ST_MEAN1_W) begin
			sum_sel = sum1_q;
			cnt_sel = cnt1_q;
		end else begin
			sum_sel = sum0_q;
			cnt_sel = cnt0_q;
		end
		a_val = (AVW'(sum_sel) <<< 1) + AVW'($signed({1'b0, cnt_sel}));
		a_neg = a_val[AVW-1];
		a_mag = a_neg ? AVW'(-a_val) : AVW'(a_val);
		mq    = (MEW+1)'(div_quo[MEW-1:0]) + (MEW+1)'(a_neg && (div_rem != '0));
		mres  = a_neg ? -$signed(mq) : $signed(mq);
	end

	always_comb begin
		dm_d    = DFW'(mean1_q) - DFW'(mean0_q);
		dev     = DFW'($signed(ram_rdata[VALUE_W-1:0]))
			- DFW'(ram_rdata[VALUE_W] ? mean1_q : mean0_q);
		dev_mag = dev[DFW-1] ? UW'(-dev) : UW'(dev);
		dm_mag  = dm_q[DFW-1] ? DFW'(-dm_q) : DFW'(dm_q);
		expo    = 6'(VAR_FRAC_HALF) + 6'(s_q[5:1]);
		t_num   = DVW'(dm_mag) << expo;
		t_lim   = dm_q[DFW-1] ? DVW'(33'h1_0000_0000 >> 1) : DVW'(32'h7FFF_FFFF);
		sq_trial = sq_res_q + sq_bit_q;
		sq_ge    = sq_rem_q >= sq_trial;
	end

	// Divider operand selection.
	always_comb begin
		unique case (state_q)
			ST_VAR_DIV: begin
				div_dvd = DVW'(mul_acc_q);
				div_dsr = divisor_q;
			end
			ST_TDIV: begin
				div_dvd = t_num;
				div_dsr = DSW'(sq_res_q[VALUE_W-1:0]);
			end
			default: begin
				div_dvd = DVW'(a_mag);
				div_dsr = DSW'({cnt_sel, 1'b0});
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:      if (accept && samples.last_sample) state_d = ST_CHECK;
			ST_CHECK: begin
				priority if (cnt0_q == '0 || cnt1_q == '0) state_d = ST_FIN;
				else if (n_tot < CW'(3))                  state_d = ST_FIN;
				else                                       state_d = ST_MEAN0;
			end
			ST_MEAN0:     state_d = ST_MEAN0_W;
			ST_MEAN0_W:   if (div_stat.done) state_d = ST_MEAN1;
			ST_MEAN1:     state_d = ST_MEAN1_W;
			ST_MEAN1_W:   if (div_stat.done) state_d = ST_DM;
			ST_DM:        state_d = (dm_d == '0) ? ST_FIN : ST_SS_ADDR;
			ST_SS_ADDR:   state_d = ST_SS_DIFF;
			ST_SS_DIFF:   state_d = ST_SS_MUL;
			ST_SS_MUL:    if (mul_cnt_q == MKW'(1)) state_d = ST_SS_ACC;
			ST_SS_ACC:    state_d = (idx_q + CW'(1) == n_tot) ? ST_VAR_MUL : ST_SS_ADDR;
			ST_VAR_MUL:   state_d = ST_VAR_MUL_W;
			ST_VAR_MUL_W: if (mul_cnt_q == MKW'(1)) state_d = ST_VAR_DIV;
			ST_VAR_DIV:   state_d = ST_VAR_DIV_W;
			ST_VAR_DIV_W: if (div_stat.done) state_d = ST_NORM;
			ST_NORM:      if (w_q >= NORM_TOP) state_d = ST_SQRT;
			ST_SQRT:      if (sq_bit_q == 64'd1) state_d = ST_TDIV;
			ST_TDIV:      state_d = ST_TDIV_W;
			ST_TDIV_W:    if (div_stat.done) state_d = ST_FIN;
			ST_FIN:       if (!out_valid_q || results.ready) state_d = ST_LOAD;
			default:      state_d = ST_LOAD;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready  = state_q == ST_LOAD;
		ram_re    = state_q == ST_SS_ADDR;
		div_start = state_q == ST_MEAN0 || state_q == ST_MEAN1
			|| state_q == ST_VAR_DIV || state_q == ST_TDIV;
		out_load  = state_q == ST_FIN && (!out_valid_q || results.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			sum0_q      <= '0;
			sum1_q      <= '0;
			cnt0_q      <= '0;
			cnt1_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// accumulate counted samples; clear once the result is placed
			if (out_load) begin
				sum0_q <= '0;
				sum1_q <= '0;
				cnt0_q <= '0;
				cnt1_q <= '0;
			end else if (accept && !full) begin
				if (samples.group_label) begin
					sum1_q <= sum1_q + SW'(samples.sample_value);
					cnt1_q <= cnt1_q + CW'(1);
				end else begin
					sum0_q <= sum0_q + SW'(samples.sample_value);
					cnt0_q <= cnt0_q + CW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Finishing datapath.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_t_q  <= res_t_q;
			out_st_q <= res_st_q;
		end
		unique case (state_q)
			ST_CHECK: begin
				res_t_q <= '0;
				priority if (cnt0_q == '0 || cnt1_q == '0) res_st_q <= STAT_EMPTY;
				else if (n_tot < CW'(3))                  res_st_q <= STAT_FEW;
				else                                       res_st_q <= STAT_OK;
			end
			ST_MEAN0_W: if (div_stat.done) mean0_q <= mres[MEW-1:0];
			ST_MEAN1_W: if (div_stat.done) mean1_q <= mres[MEW-1:0];
			ST_DM: begin
				dm_q  <= dm_d;
				idx_q <= '0;
				ss_q  <= '0;
			end
			ST_SS_DIFF: begin
				// square |x - mean| one multiplier bit per cycle
				mul_a_q   <= MW'(dev_mag);
				mul_b_q   <= dev_mag;
				mul_acc_q <= '0;
				mul_cnt_q <= MKW'(UW);
			end
			ST_SS_MUL, ST_VAR_MUL_W: begin
				if (mul_b_q[0]) begin
					mul_acc_q <= mul_acc_q + mul_a_q;
				end
				mul_a_q   <= mul_a_q << 1;
				mul_b_q   <= mul_b_q >> 1;
				mul_cnt_q <= mul_cnt_q - MKW'(1);
				divisor_q <= DSW'((3*CW)'(pdiv1_q) * (3*CW)'(cnt1_q));
			end
			ST_SS_ACC: begin
				ss_q  <= ss_q + SSW'(mul_acc_q[MW-1:SQ_SHIFT]);
				idx_q <= idx_q + CW'(1);
			end
			ST_VAR_MUL: begin
				// ss * n, then divide by (n-2) * c0 * c1
				mul_a_q   <= MW'(ss_q);
				mul_b_q   <= UW'(n_tot);
				mul_acc_q <= '0;
				mul_cnt_q <= MKW'(UW);
				pdiv1_q   <= (2*CW)'(n_tot - CW'(2)) * (2*CW)'(cnt0_q);
			end
			ST_VAR_DIV_W: begin
				// guard term of one unit keeps the root nonzero
				if (div_stat.done) begin
					w_q <= div_quo[63:0] + 64'd1;
					s_q <= '0;
				end
			end
			ST_NORM: begin
				if (w_q < NORM_TOP) begin
					w_q <= w_q << 2;
					s_q <= s_q + 6'd2;
				end else begin
					sq_rem_q <= w_q;
					sq_res_q <= '0;
					sq_bit_q <= NORM_TOP;
				end
			end
			ST_SQRT: begin
				if (sq_ge) begin
					sq_rem_q <= sq_rem_q - sq_trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_TDIV_W: begin
				if (div_stat.done) begin
					if (div_quo > t_lim) begin
						res_t_q  <= dm_q[DFW-1] ? $signed(32'h8000_0000)
							: $signed(32'h7FFF_FFFF);
						res_st_q <= STAT_SAT;
					end else begin
						res_t_q  <= dm_q[DFW-1] ? -$signed(div_quo[VALUE_W-1:0])
							: $signed(div_quo[VALUE_W-1:0]);
						res_st_q <= STAT_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign samples.ready       = in_ready;
	assign results.valid       = out_valid_q;
	assign results.t_statistic = out_t_q;
	assign results.status      = out_st_q;

`ifndef SYNTH
	// the sample count never runs past the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt0_q + cnt1_q) <= MAX_SAMPLES)
		else $error("sample count past store depth");

	// special-case results carry a zero statistic
	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.status == STAT_EMPTY || results.status == STAT_FEW))
		|-> results.t_statistic == '0)
		else $error("nonzero statistic on special case");

	// saturated results sit at a range end
	a_sat_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status == STAT_SAT)
		|-> (results.t_statistic == $signed(32'h7FFF_FFFF)
			|| results.t_statistic == $signed(32'h8000_0000)))
		else $error("saturated result not at range end");

	// the divider is never restarted while busy
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the pooled two-sample t statistic block.
`default_nettype none

// Holds the expected t statistics and compares the block's results with them.
class t_stat_scoreboard;
	localparam int STORE_DEPTH = pts_pkg::MAX_SAMPLES_DEF;

	longint     kept_value[STORE_DEPTH];
	bit         kept_group[STORE_DEPTH];
	longint     sum0, sum1;
	int unsigned cnt0, cnt1;
	bit [31:0]  want_t[$];
	pts_pkg::status_t want_status[$];
	int unsigned mismatches;

	function new();
		sum0 = 0;
		sum1 = 0;
		cnt0 = 0;
		cnt1 = 0;
		mismatches = 0;
	endfunction

	function int pending();
		return want_t.size();
	endfunction

	static function longint rounded_mean(longint sum, int unsigned cnt);
		longint a, b, q;
		a = 2 * sum + longint'(cnt);
		b = 2 * longint'(cnt);
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	static function bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] root, bit_pos;
		root = 0;
		bit_pos = 64'd1 << 62;
		while (bit_pos > v)
			bit_pos >>= 2;
		while (bit_pos != 0) begin
			if (v >= root + bit_pos) begin
				v -= root + bit_pos;
				root = (root >> 1) + bit_pos;
			end else begin
				root >>= 1;
			end
			bit_pos >>= 2;
		end
		return root;
	endfunction

	// Work out the t statistic of the gene just closed.
	function void close_gene(output bit [31:0] t, output pts_pkg::status_t st);
		int unsigned n, s, e, e1, e2;
		longint m0, m1, d, dm;
		bit [63:0] ss, u, dv, v, w, mag, r, num, q, rr, lim;
		n = cnt0 + cnt1;
		t = 0;
		st = pts_pkg::STAT_OK;
		if (cnt0 == 0 || cnt1 == 0) begin
			st = pts_pkg::STAT_EMPTY;
			return;
		end
		if (n < 3) begin
			st = pts_pkg::STAT_FEW;
			return;
		end
		m0 = rounded_mean(sum0, cnt0);
		m1 = rounded_mean(sum1, cnt1);
		ss = 0;
		for (int i = 0; i < n && i < STORE_DEPTH; i++) begin
			d = kept_value[i] - (kept_group[i] ? m1 : m0);
			u = d < 0 ? -d : d;
			ss += (u * u) >> pts_pkg::SQ_SHIFT;
		end
		dv = 64'(n - 2) * cnt0 * cnt1;
		v = (ss / dv) * n + ((ss % dv) * n) / dv;
		w = v + 1;
		dm = m1 - m0;
		if (dm == 0)
			return;
		mag = dm < 0 ? -dm : dm;
		s = 0;
		while (w < pts_pkg::NORM_TOP) begin
			w <<= 2;
			s += 2;
		end
		r = int_sqrt(w);
		e = pts_pkg::VAR_FRAC_HALF + s / 2;
		e1 = e < pts_pkg::EXP_MAX ? e : pts_pkg::EXP_MAX;
		e2 = e - e1;
		num = mag << e1;
		q = num / r;
		rr = num % r;
		if (e2 > 0)
			q = (q << e2) + ((rr << e2) / r);
		lim = dm > 0 ? 64'h7FFF_FFFF : 64'h8000_0000;
		if (q > lim) begin
			t = dm > 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
			st = pts_pkg::STAT_SAT;
			return;
		end
		t = dm > 0 ? q[31:0] : 32'(-q);
	endfunction

	// Note one accepted sample request.
	function void note_sample(logic signed [31:0] value, logic grp, logic last);
		int unsigned n;
		bit [31:0] t;
		pts_pkg::status_t st;
		n = cnt0 + cnt1;
		if (n < STORE_DEPTH) begin
			kept_value[n] = value;
			kept_group[n] = grp;
			if (grp) begin
				sum1 += value;
				cnt1++;
			end else begin
				sum0 += value;
				cnt0++;
			end
		end
		if (!last)
			return;
		close_gene(t, st);
		want_t = {want_t, t};
		want_status = {want_status, st};
		sum0 = 0;
		sum1 = 0;
		cnt0 = 0;
		cnt1 = 0;
	endfunction

	// Compare one accepted result request with the oldest expectation.
	function void check_result(logic [31:0] t, logic [1:0] st);
		bit [31:0] et;
		pts_pkg::status_t es;
		if (want_t.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: t=%h status=%0d", t, st);
			return;
		end
		et = want_t.pop_front();
		es = want_status.pop_front();
		if (t !== et || st !== es) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected t=%h status=%0d, got t=%h status=%0d",
					et, es, t, st);
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1650;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 400;

	logic clk;
	logic arst_n;
	pts_in_if  samples();
	pts_out_if results();

	t_stat_scoreboard sb;
	int unsigned sent;
	int unsigned cycles = 0;
	int unsigned idle_pct;
	int unsigned stall_pct;

	pooled_two_sample_t_statistic_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stall the result channel at the rate of the current phase.
	always @(posedge clk) begin
		if (!arst_n)
			results.ready <= 1'b0;
		else
			results.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Inputs only move at rising edges, so the handshake is settled at the
	// falling edge and the request completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && results.valid && results.ready)
			sb.check_result(results.t_statistic, results.status);
	end

	// Send one sample request and hold it until taken.
	task automatic send_sample(input logic signed [31:0] v, input logic g,
		input logic l);
		while ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample_value <= v;
		samples.group_label <= g;
		samples.last_sample <= l;
		forever begin
			@(negedge clk);
			if (samples.ready)
				break;
		end
		@(posedge clk);
		sb.note_sample(v, g, l);
		sent++;
	endtask

	// Stream one gene: samples draw around a per-group center, or span the whole range when wide.
	task automatic send_gene(input int unsigned len, input logic signed [31:0] c0,
		input logic signed [31:0] c1, input int unsigned spread, input bit wide);
		logic g;
		logic signed [31:0] v;
		for (int unsigned i = 0; i < len; i++) begin
			g = 1'($urandom_range(1));
			if (wide)
				v = $urandom;
			else
				v = (g ? c1 : c0) + $signed($urandom_range(2 * spread)) -
					$signed(spread);
			send_sample(v, g, i == len - 1);
		end
	endtask

	// Adjust idling as the run progresses: none, sender, receiver, both.
	task automatic pick_phase();
		case ((sent * 4) / ITEM_TARGET)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 65;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 65;
			end
			default: begin
				idle_pct = 37;
				stall_pct = 37;
			end
		endcase
		// Leave a stretch without idling now and then.
		if ($urandom_range(7) == 0) begin
			idle_pct = 0;
			stall_pct = 0;
		end
	endtask

	initial begin
		int unsigned len, spread, kind;
		logic signed [31:0] c0, c1;
		sb = new();
		sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n <= 1'b0;
		samples.valid <= 1'b0;
		samples.sample_value <= '0;
		samples.group_label <= 1'b0;
		samples.last_sample <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a lone sample leaves a group empty.
		send_sample(32'sh7FFF_FFFF, 1'b1, 1'b1);
		// One group only.
		send_sample(32'sh8000_0000, 1'b0, 1'b0);
		send_sample(32'sh0001_0000, 1'b0, 1'b1);
		// Both groups but only two samples.
		send_sample(32'sh8000_0000, 1'b0, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b1, 1'b1);
		// Extremes with three samples.
		send_sample(32'sh8000_0000, 1'b0, 1'b0);
		send_sample(32'sh8000_0000, 1'b0, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b1, 1'b1);
		// Constant groups: no spread, so the variance is only the guard term.
		send_sample(32'sh0001_0000, 1'b0, 1'b0);
		send_sample(32'sh0001_0000, 1'b0, 1'b0);
		send_sample(32'sh0002_0000, 1'b1, 1'b0);
		send_sample(32'sh0002_0000, 1'b1, 1'b1);
		// Equal means.
		send_sample(-32'sh0001_0000, 1'b0, 1'b0);
		send_sample(32'sh0003_0000, 1'b0, 1'b0);
		send_sample(32'sh0001_0000, 1'b1, 1'b0);
		send_sample(32'sh0001_0000, 1'b1, 1'b1);
		// Positive difference with no spread.
		send_sample(32'sh0005_0000, 1'b1, 1'b0);
		send_sample(32'sh0000_0000, 1'b0, 1'b0);
		send_sample(32'sh0005_0000, 1'b1, 1'b1);
		// Full store, with the last mark on a dropped sample.
		send_gene(70, 32'sh0000_8000, -32'sh0000_8000, 32'h0002_0000, 1'b0);

		while (sent < ITEM_TARGET) begin
			pick_phase();
			kind = $urandom_range(19);
			c0 = $urandom;
			c1 = ($urandom_range(3) == 0) ? c0 : (c0 + $signed($urandom_range(32'hFFFF)));
			spread = 1 << $urandom_range(20);
			if (kind < 12)
				len = $urandom_range(3, 16);
			else if (kind < 15)
				len = $urandom_range(1, 3);
			else if (kind < 17)
				len = $urandom_range(17, 40);
			else
				len = $urandom_range(60, 68);
			if (kind == 19)
				spread = 0;
			send_gene(len, c0, c1, spread, kind == 18);
		end

		samples.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// File: pooled_two_sample_t_statistic_top.f
src/pts_pkg.sv
src/pts_in_if.sv
src/pts_out_if.sv
src/pts_ram.sv
src/pts_sdiv.sv
src/pooled_two_sample_t_statistic_top.sv
tb/testbench.sv
